>>> rtl/upsdc_pkg.sv
`timescale 1ns / 1ps

package upsdc_pkg;

    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 32;

    localparam logic RegDcCoeff = 1'b0;
    localparam logic RegGain    = 1'b1;

    localparam logic [15:0] DcCoeffRst = 16'd65208;
    localparam logic [11:0] GainRst    = 12'd384;

    localparam int MulAW    = 24;
    localparam int MulBW    = 25;
    localparam int ProdW    = MulAW + MulBW;
    localparam int DivShift = 24;
    localparam int YW       = 48;

    localparam logic signed [15:0] PcmMax = 16'sh7fff;
    localparam logic signed [15:0] PcmMin = 16'sh8000;

    typedef struct packed {
        logic signed [15:0] pcm_in;
        logic               clear_history;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] pcm_out;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] dc_coeff;
        logic [11:0] gain;
    } t_cfg;

endpackage

>>> rtl/upsdc_mul.sv
`timescale 1ns / 1ps

module upsdc_mul (
    input  logic                        i_clk,
    input  logic [upsdc_pkg::MulAW-1:0] i_a,
    input  logic [upsdc_pkg::MulBW-1:0] i_b,
    output logic [upsdc_pkg::ProdW-1:0] o_prod
);
    import upsdc_pkg::*;

    logic [ProdW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= ProdW'(i_a) * ProdW'(i_b);
    end

    assign o_prod = r_prod;

endmodule

>>> rtl/upsdc_cfg.sv
`timescale 1ns / 1ps

module upsdc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [upsdc_pkg::CfgAddrW-1:0] paddr,
    input  logic [upsdc_pkg::CfgDataW-1:0] pwdata,
    output logic [upsdc_pkg::CfgDataW-1:0] prdata,
    output logic                           pready,
    output upsdc_pkg::t_cfg                o_cfg
);
    import upsdc_pkg::*;

    logic [15:0] r_dc_coeff;
    logic [11:0] r_gain;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc_coeff <= DcCoeffRst;
            r_gain     <= GainRst;
        end else if (w_wr) begin
            unique case (paddr[2])
                RegDcCoeff: r_dc_coeff <= pwdata[15:0];
                RegGain:    r_gain     <= pwdata[11:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            RegDcCoeff: prdata = {16'b0, r_dc_coeff};
            RegGain:    prdata = {20'b0, r_gain};
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = '{dc_coeff: r_dc_coeff, gain: r_gain};

endmodule

>>> rtl/upsdc_core.sv
`timescale 1ns / 1ps

module upsdc_core #(
    parameter int UPSAMPLE_FACTOR = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  upsdc_pkg::t_cfg      i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  upsdc_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output upsdc_pkg::t_out_item o_out_data
);
    import upsdc_pkg::*;

    localparam int NumW = 18 + $clog2(UPSAMPLE_FACTOR);
    localparam int CntW = (UPSAMPLE_FACTOR > 1) ? $clog2(UPSAMPLE_FACTOR) : 1;
    localparam logic [CntW-1:0] CntLast = CntW'(UPSAMPLE_FACTOR - 1);
    localparam logic [MulBW-1:0] DivRecip =
        MulBW'(((1 << DivShift) + UPSAMPLE_FACTOR - 1) / UPSAMPLE_FACTOR);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_DIV   = 12'b0000_0000_0010,
        ST_FBL   = 12'b0000_0000_0100,
        ST_FBH   = 12'b0000_0000_1000,
        ST_FBSUM = 12'b0000_0001_0000,
        ST_YFIN  = 12'b0000_0010_0000,
        ST_MAG   = 12'b0000_0100_0000,
        ST_GL    = 12'b0000_1000_0000,
        ST_GH    = 12'b0001_0000_0000,
        ST_GSUM  = 12'b0010_0000_0000,
        ST_SAT   = 12'b0100_0000_0000,
        ST_OUT   = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic signed [NumW-1:0] r_num;
    logic signed [16:0]     r_d;
    logic [CntW-1:0]        r_cnt;
    logic signed [15:0]     r_prev;
    logic                   r_prev_valid;
    logic                   r_xneg;
    logic signed [15:0]     r_x;
    logic signed [15:0]     r_xlast;
    logic signed [16:0]     r_diff;
    logic [ProdW-1:0]       r_acc;
    logic signed [YW-1:0]   r_y;
    logic [YW-1:0]          r_ymag;
    logic                   r_yneg;
    logic signed [15:0]     r_pcm;
    logic                   r_last;

    logic                   w_accept;
    logic                   w_out_take;
    logic signed [15:0]     w_start;
    logic signed [16:0]     w_d;
    logic signed [NumW-1:0] w_num0;
    logic [NumW-1:0]        w_num_abs;
    logic [16:0]            w_q;
    logic [16:0]            w_xq;
    logic [63:0]            w_fbsum;
    logic signed [48:0]     w_diff_ext;
    logic signed [48:0]     w_fb_ext;
    logic signed [48:0]     w_ysum;
    logic [YW-1:0]          w_ysat;
    logic [YW-1:0]          w_ymag;
    logic [36:0]            w_zmag;
    logic [36:0]            w_zacc;
    logic signed [15:0]     w_pcm;
    logic [MulAW-1:0]       w_mul_a;
    logic [MulBW-1:0]       w_mul_b;
    logic [ProdW-1:0]       w_prod;

    upsdc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_take = (r_state == ST_OUT) && !i_out_stall;

    assign w_start = (i_in_data.clear_history || !r_prev_valid) ? i_in_data.pcm_in : r_prev;
    assign w_d     = {i_in_data.pcm_in[15], i_in_data.pcm_in} - {w_start[15], w_start};
    assign w_num0  = NumW'(w_start) * NumW'(UPSAMPLE_FACTOR) + NumW'(w_d);

    assign w_num_abs = r_num[NumW-1] ? NumW'(-r_num) : NumW'(r_num);
    assign w_q       = w_prod[DivShift +: 17];
    assign w_xq      = r_xneg ? (17'd0 - w_q) : w_q;

    assign w_fbsum = {w_prod[39:0], 24'b0} + {24'b0, r_acc[39:0]};

    assign w_diff_ext = {{16{r_diff[16]}}, r_diff, 16'b0};
    assign w_fb_ext   = {1'b0, r_acc[YW-1:0]};
    assign w_ysum     = r_yneg ? (w_diff_ext - w_fb_ext) : (w_diff_ext + w_fb_ext);
    assign w_ysat     = (w_ysum[48] != w_ysum[47])
                        ? (w_ysum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}})
                        : w_ysum[YW-1:0];

    assign w_ymag = r_y[YW-1] ? YW'(-r_y) : YW'(r_y);

    assign w_zmag = {1'b0, w_prod[35:0]} + 37'(r_acc[ProdW-1:24]);
    assign w_zacc = r_acc[36:0];

    always_comb begin
        if (!r_yneg) begin
            w_pcm = (w_zacc > 37'd32767) ? PcmMax : signed'(w_zacc[15:0]);
        end else begin
            w_pcm = (w_zacc > 37'd32768) ? PcmMin : signed'(16'd0 - w_zacc[15:0]);
        end
    end

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            ST_DIV: begin
                w_mul_a = MulAW'(w_num_abs);
                w_mul_b = DivRecip;
            end
            ST_FBL: begin
                w_mul_a = r_ymag[23:0];
                w_mul_b = MulBW'(i_cfg.dc_coeff);
            end
            ST_FBH: begin
                w_mul_a = r_ymag[47:24];
                w_mul_b = MulBW'(i_cfg.dc_coeff);
            end
            ST_GL: begin
                w_mul_a = r_ymag[23:0];
                w_mul_b = MulBW'(i_cfg.gain);
            end
            ST_GH: begin
                w_mul_a = r_ymag[47:24];
                w_mul_b = MulBW'(i_cfg.gain);
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_DIV;
            ST_DIV:   n_state = ST_FBL;
            ST_FBL:   n_state = ST_FBH;
            ST_FBH:   n_state = ST_FBSUM;
            ST_FBSUM: n_state = ST_YFIN;
            ST_YFIN:  n_state = ST_MAG;
            ST_MAG:   n_state = ST_GL;
            ST_GL:    n_state = ST_GH;
            ST_GH:    n_state = ST_GSUM;
            ST_GSUM:  n_state = ST_SAT;
            ST_SAT:   n_state = ST_OUT;
            ST_OUT:   if (w_out_take) n_state = r_last ? ST_IDLE : ST_DIV;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
            r_xlast      <= '0;
            r_y          <= '0;
            r_ymag       <= '0;
            r_yneg       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_cnt        <= '0;
                r_prev       <= i_in_data.pcm_in;
                r_prev_valid <= 1'b1;
                if (i_in_data.clear_history) begin
                    r_xlast <= '0;
                    r_y     <= '0;
                    r_ymag  <= '0;
                    r_yneg  <= 1'b0;
                end
            end
            if (r_state == ST_FBSUM) begin
                r_xlast <= r_x;
            end
            if (r_state == ST_YFIN) begin
                r_y <= w_ysat;
            end
            if (r_state == ST_MAG) begin
                r_ymag <= w_ymag;
                r_yneg <= r_y[YW-1];
            end
            if (w_out_take && !r_last) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_num <= w_num0;
            r_d   <= w_d;
        end
        if (w_out_take) begin
            r_num <= r_num + NumW'(r_d);
        end
        unique case (r_state)
            ST_DIV:   r_xneg <= r_num[NumW-1];
            ST_FBL:   r_x    <= w_xq[15:0];
            ST_FBH:   r_acc  <= w_prod;
            ST_FBSUM: begin
                r_acc  <= ProdW'(w_fbsum[63:16]);
                r_diff <= {r_x[15], r_x} - {r_xlast[15], r_xlast};
            end
            ST_GH:    r_acc <= w_prod;
            ST_GSUM:  r_acc <= ProdW'(w_zmag);
            ST_SAT: begin
                r_pcm  <= w_pcm;
                r_last <= (r_cnt == CntLast);
            end
            default: ;
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_out_data  = '{pcm_out: r_pcm, last: r_last};

endmodule

>>> rtl/upsample_dc_block_gain_unit.sv
`timescale 1ns / 1ps

// Channel   Handshake                     Payload
// input     i_in_valid / o_in_stall       i_in_data  (pcm_in, clear_history)
// output    o_out_valid / i_out_stall     o_out_data (pcm_out, last)
// config    psel penable pwrite pready    paddr, pwdata, prdata
//
// Each output sample steps through DIV, FBL, FBH, FBSUM, YFIN, MAG, GL, GH,
// GSUM, SAT and OUT, using one shared 24x25 multiplier, and waits in OUT on
// i_out_stall; an input item gives UPSAMPLE_FACTOR samples. The input is
// stalled from acceptance until its last sample is taken. Synchronous
// active-low reset clears history and filter state, presets config regs.

module upsample_dc_block_gain_unit #(
    parameter int UPSAMPLE_FACTOR = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  upsdc_pkg::t_in_item            i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output upsdc_pkg::t_out_item           o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [upsdc_pkg::CfgAddrW-1:0] paddr,
    input  logic [upsdc_pkg::CfgDataW-1:0] pwdata,
    output logic [upsdc_pkg::CfgDataW-1:0] prdata,
    output logic                           pready
);
    import upsdc_pkg::*;

    t_cfg w_cfg;

    upsdc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    upsdc_core #(
        .UPSAMPLE_FACTOR (UPSAMPLE_FACTOR)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
